[rtl/crc8_word_frame_codec_defines.svh]
// Assertion macros for the word framing codec.
`ifndef CRC8_WORD_FRAME_CODEC_DEFINES_SVH
`define CRC8_WORD_FRAME_CODEC_DEFINES_SVH

// Checks that a condition holds at every clock edge outside reset.
`define CRC8WFC_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Checks that a consequence holds whenever its antecedent holds.
`define CRC8WFC_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

[rtl/crc8wfc_pkg.sv]
`default_nettype none

package crc8wfc_pkg;

  localparam int MAX_WORDS_DEFAULT = 16;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_TOP = 8'h80;

  localparam logic [4:0] WPF_RESET = 5'd2;

  localparam logic [1:0] FUNC_RESYNC = 2'd0;
  localparam logic [1:0] FUNC_RX = 2'd1;
  localparam logic [1:0] FUNC_TX = 2'd2;

  localparam logic KIND_TX = 1'b0;
  localparam logic KIND_RX = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [15:0] word;
    logic [7:0]  crc;
    logic        word_ok;
    logic        frame_ok;
    logic        frame_end;
  } entry_t;

  function automatic logic [7:0] crc_feed(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    c = crc_in ^ data;
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 8'h00) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/crc8wfc_fifo.sv]
`default_nettype none

module crc8wfc_fifo
  import crc8wfc_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire    clk,
  input  wire    rst,
  input  wire    push,
  input  entry_t push_entry,
  output logic   full,
  input  wire    pop,
  output entry_t head,
  output logic   empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/crc8wfc_front.sv]
`default_nettype none

module crc8wfc_front
  import crc8wfc_pkg::*;
#(
  parameter int MAX_WORDS = MAX_WORDS_DEFAULT
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_wr_en,
  input  wire  [4:0]  cfg_wr_data,
  input  wire         accept,
  input  wire  [1:0]  func,
  input  wire  [7:0]  rx_byte,
  input  wire  [15:0] tx_word,
  output logic        push,
  output entry_t      push_entry
);

  localparam int IDX_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int CMP_W = ($clog2(MAX_WORDS + 1) > 5) ? $clog2(MAX_WORDS + 1) : 5;

  logic [1:0]       byte_position;
  logic [IDX_W-1:0] word_index;
  logic [7:0]       held_msb;
  logic [7:0]       held_lsb;
  logic [7:0]       running_crc;
  logic             frame_good;
  logic [4:0]       words_per_frame;

  logic [7:0]       crc_in;
  logic [7:0]       crc_rx;
  logic [7:0]       crc_tx_hi;
  logic [CMP_W-1:0] frame_len;
  logic             ok;
  logic             fok;
  logic             fend;

  assign crc_in = (byte_position == 2'd0) ? CRC_INIT : running_crc;
  assign crc_rx = crc_feed(crc_in, rx_byte);
  assign crc_tx_hi = crc_feed(CRC_INIT, tx_word[15:8]);

  always_comb begin
    if (words_per_frame == 5'd0) begin
      frame_len = CMP_W'(1);
    end else if (CMP_W'(words_per_frame) > CMP_W'(MAX_WORDS)) begin
      frame_len = CMP_W'(MAX_WORDS);
    end else begin
      frame_len = CMP_W'(words_per_frame);
    end
  end

  assign ok = (running_crc == rx_byte);
  assign fok = frame_good & ok;
  assign fend = ((CMP_W'(word_index) + CMP_W'(1)) >= frame_len);

  always_comb begin
    push = 1'b0;
    push_entry.kind = KIND_RX;
    push_entry.word = {held_msb, held_lsb};
    push_entry.crc = crc_tx_hi;
    push_entry.word_ok = ok;
    push_entry.frame_ok = fok;
    push_entry.frame_end = fend;
    if (accept && func == FUNC_RX && byte_position == 2'd2) begin
      push = 1'b1;
    end else if (accept && func == FUNC_TX) begin
      push = 1'b1;
      push_entry.kind = KIND_TX;
      push_entry.word = tx_word;
      push_entry.word_ok = 1'b0;
      push_entry.frame_ok = 1'b0;
      push_entry.frame_end = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      words_per_frame <= WPF_RESET;
    end else if (cfg_wr_en) begin
      words_per_frame <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 2'd0;
      word_index <= '0;
      held_msb <= 8'h00;
      held_lsb <= 8'h00;
      running_crc <= CRC_INIT;
      frame_good <= 1'b1;
    end else if (accept) begin
      unique case (func)
        FUNC_RESYNC: begin
          byte_position <= 2'd0;
          word_index <= '0;
          running_crc <= CRC_INIT;
          frame_good <= 1'b1;
        end
        FUNC_RX: begin
          unique case (byte_position)
            2'd0: begin
              held_msb <= rx_byte;
              running_crc <= crc_rx;
              byte_position <= 2'd1;
            end
            2'd1: begin
              held_lsb <= rx_byte;
              running_crc <= crc_rx;
              byte_position <= 2'd2;
            end
            default: begin
              if (fend) begin
                word_index <= '0;
                frame_good <= 1'b1;
              end else begin
                word_index <= word_index + 1'b1;
                frame_good <= fok;
              end
              byte_position <= 2'd0;
              running_crc <= CRC_INIT;
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/crc8wfc_back.sv]
`default_nettype none

module crc8wfc_back
  import crc8wfc_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  entry_t      head,
  input  wire         empty,
  output logic        pop,
  output logic        out_valid,
  input  wire         out_ready,
  output logic        result_kind,
  output logic [7:0]  tx_byte,
  output logic [15:0] rx_word,
  output logic        word_ok,
  output logic        frame_ok,
  output logic        frame_end,
  output logic        run_end
);

  localparam logic [1:0] STEP_HI = 2'd0;
  localparam logic [1:0] STEP_LO = 2'd1;
  localparam logic [1:0] STEP_CRC = 2'd2;

  logic [1:0] step;
  logic [1:0] step_next;
  logic [7:0] crc_reg;
  logic       load;

  assign load = !empty && (!out_valid || out_ready);

  always_comb begin
    step_next = step;
    pop = 1'b0;
    if (load) begin
      if (head.kind == KIND_RX) begin
        pop = 1'b1;
      end else begin
        unique case (step)
          STEP_HI: step_next = STEP_LO;
          STEP_LO: step_next = STEP_CRC;
          default: begin
            step_next = STEP_HI;
            pop = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step <= STEP_HI;
    end else begin
      step <= step_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (head.kind == KIND_RX) begin
        result_kind <= KIND_RX;
        tx_byte <= 8'h00;
        rx_word <= head.word;
        word_ok <= head.word_ok;
        frame_ok <= head.frame_ok;
        frame_end <= head.frame_end;
        run_end <= 1'b1;
      end else begin
        result_kind <= KIND_TX;
        rx_word <= 16'h0000;
        word_ok <= 1'b0;
        frame_ok <= 1'b0;
        frame_end <= 1'b0;
        unique case (step)
          STEP_HI: begin
            tx_byte <= head.word[15:8];
            run_end <= 1'b0;
            crc_reg <= crc_feed(head.crc, head.word[7:0]);
          end
          STEP_LO: begin
            tx_byte <= head.word[7:0];
            run_end <= 1'b0;
          end
          default: begin
            tx_byte <= crc_reg;
            run_end <= 1'b1;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

[rtl/crc8_word_frame_codec.sv]
// A result is written into the queue and then into the output registers of the back end.
// One received byte is taken per cycle while the queue is not full; a word to
// transmit gives three results, one per framed byte on the result channel, and
// the queue depth sets how far input runs ahead of a stalled output.
// Reset (rst, synchronous, active high) empties the queue, restarts the receive
// counters with the CRC at 0xFF and the frame marked good, and sets the frame length to 2.
`default_nettype none

`include "crc8_word_frame_codec_defines.svh"

module crc8_word_frame_codec
  import crc8wfc_pkg::*;
#(
  parameter int MAX_WORDS = MAX_WORDS_DEFAULT,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_wr_en,
  input  wire  [4:0]  cfg_wr_data,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [1:0]  func,
  input  wire  [7:0]  rx_byte,
  input  wire  [15:0] tx_word,
  output logic        out_valid,
  input  wire         out_ready,
  output logic        result_kind,
  output logic [7:0]  tx_byte,
  output logic [15:0] rx_word,
  output logic        word_ok,
  output logic        frame_ok,
  output logic        frame_end,
  output logic        run_end
);

  logic   accept;
  logic   push;
  entry_t push_entry;
  logic   full;
  logic   pop;
  entry_t head;
  logic   empty;

  assign in_ready = !full;
  assign accept = in_valid && in_ready;

  crc8wfc_front #(
    .MAX_WORDS(MAX_WORDS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .accept(accept),
    .func(func),
    .rx_byte(rx_byte),
    .tx_word(tx_word),
    .push(push),
    .push_entry(push_entry)
  );

  crc8wfc_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_entry(push_entry),
    .full(full),
    .pop(pop),
    .head(head),
    .empty(empty)
  );

  crc8wfc_back u_back (
    .clk(clk),
    .rst(rst),
    .head(head),
    .empty(empty),
    .pop(pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .result_kind(result_kind),
    .tx_byte(tx_byte),
    .rx_word(rx_word),
    .word_ok(word_ok),
    .frame_ok(frame_ok),
    .frame_end(frame_end),
    .run_end(run_end)
  );

  `CRC8WFC_ALWAYS(a_no_overflow, !(push && full), "word pushed into a full queue")
  `CRC8WFC_ALWAYS(a_no_underflow, !(pop && empty), "word popped from an empty queue")
  `CRC8WFC_IMPLIES(a_frame_needs_word, out_valid && result_kind == KIND_RX && frame_ok, word_ok, "frame good on a failed word")
  `CRC8WFC_IMPLIES(a_tx_fields_clear, out_valid && result_kind == KIND_TX, rx_word == 16'h0000 && !word_ok && !frame_ok && !frame_end, "transmit result carries receive fields")

endmodule

`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import crc8wfc_pkg::*;

  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 300000;
  localparam int LONG_HOLD = 60;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_WORDS = 29;
  localparam int NUM_PHASES = 8;

  typedef struct packed {
    logic        kind;
    logic [7:0]  txb;
    logic [15:0] word;
    logic        wok;
    logic        fok;
    logic        fend;
    logic        rend;
  } codec_out_t;

  typedef struct packed {
    logic [1:0]  f;
    logic [7:0]  rb;
    logic [15:0] tw;
    logic        typed;
    codec_out_t  want;
  } word_row_t;

  localparam codec_out_t NONE = '0;

  localparam word_row_t DIRECTED_ROWS [0:23] = '{
    '{FUNC_TX, 8'h00, 16'h0000, 1'b1, '{KIND_TX, 8'h81, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b1}},
    '{FUNC_TX, 8'h00, 16'hFFFF, 1'b0, NONE},
    '{FUNC_TX, 8'h00, 16'hBEEF, 1'b1, '{KIND_TX, 8'h92, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b1}},
    '{FUNC_RX, 8'hBE, 16'h0000, 1'b0, NONE},
    '{FUNC_RX, 8'hEF, 16'h0000, 1'b0, NONE},
    '{FUNC_RX, 8'h92, 16'h0000, 1'b1, '{KIND_RX, 8'h00, 16'hBEEF, 1'b1, 1'b1, 1'b0, 1'b1}},
    '{FUNC_RX, 8'h00, 16'h0000, 1'b0, NONE},
    '{FUNC_RX, 8'h00, 16'h0000, 1'b0, NONE},
    '{FUNC_RX, 8'h00, 16'h0000, 1'b1, '{KIND_RX, 8'h00, 16'h0000, 1'b0, 1'b0, 1'b1, 1'b1}},
    '{FUNC_RX, 8'hFF, 16'h0000, 1'b0, NONE},
    '{FUNC_SPARE, 8'hFF, 16'hFFFF, 1'b0, NONE},
    '{FUNC_RX, 8'hFF, 16'h0000, 1'b0, NONE},
    '{FUNC_TX, 8'h00, 16'h1234, 1'b0, NONE},
    '{FUNC_RX, 8'h00, 16'h0000, 1'b0, NONE},
    '{FUNC_RX, 8'h12, 16'h0000, 1'b0, NONE},
    '{FUNC_RESYNC, 8'hFF, 16'hFFFF, 1'b0, NONE},
    '{FUNC_RX, 8'hAB, 16'h0000, 1'b0, NONE},
    '{FUNC_RX, 8'hCD, 16'h0000, 1'b0, NONE},
    '{FUNC_RX, 8'h5A, 16'h0000, 1'b0, NONE},
    '{FUNC_RESYNC, 8'h00, 16'h0000, 1'b0, NONE},
    '{FUNC_RX, 8'h00, 16'h0000, 1'b0, NONE},
    '{FUNC_RX, 8'h00, 16'h0000, 1'b0, NONE},
    '{FUNC_RX, 8'h81, 16'h0000, 1'b1, '{KIND_RX, 8'h00, 16'h0000, 1'b1, 1'b1, 1'b0, 1'b1}},
    '{FUNC_SPARE, 8'h00, 16'h0000, 1'b0, NONE}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [4:0]  cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  func = FUNC_RESYNC;
  logic [7:0]  rx_byte = '0;
  logic [15:0] tx_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        result_kind;
  logic [7:0]  tx_byte;
  logic [15:0] rx_word;
  logic        word_ok;
  logic        frame_ok;
  logic        frame_end;
  logic        run_end;

  codec_out_t results_due[$];
  int error_count = 0;
  int cycle_count = 0;
  int send_pct = 0;
  int stall_pct = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;

  // Predictor state.
  int         rx_phase = 0;
  int         words_done = 0;
  logic [7:0] msb_hold = '0;
  logic [7:0] lsb_hold = '0;
  logic [7:0] crc_acc = CRC_INIT;
  logic       frame_clean = 1'b1;
  logic [4:0] frame_len_cfg = WPF_RESET;

  crc8_word_frame_codec u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .rx_byte     (rx_byte),
    .tx_word     (tx_word),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_kind (result_kind),
    .tx_byte     (tx_byte),
    .rx_word     (rx_word),
    .word_ok     (word_ok),
    .frame_ok    (frame_ok),
    .frame_end   (frame_end),
    .run_end     (run_end)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Serial form of the CRC: one data bit per shift, MSB first.
  function automatic logic [7:0] crc31_byte(input logic [7:0] acc, input logic [7:0] d);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = acc[7] ^ d[i];
      acc = {acc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return acc;
  endfunction

  function automatic int effective_frame_len();
    if (frame_len_cfg == 5'd0) begin
      return 1;
    end
    if (int'(frame_len_cfg) > MAX_WORDS_DEFAULT) begin
      return MAX_WORDS_DEFAULT;
    end
    return int'(frame_len_cfg);
  endfunction

  task automatic codec_predict(input logic [1:0] f, input logic [7:0] rb,
                               input logic [15:0] tw);
    logic ok;
    logic fend;
    logic [7:0] tx_crc;
    case (f)
      FUNC_RESYNC: begin
        rx_phase = 0;
        words_done = 0;
        crc_acc = CRC_INIT;
        frame_clean = 1'b1;
      end
      FUNC_RX: begin
        if (rx_phase == 0) begin
          msb_hold = rb;
          crc_acc = crc31_byte(CRC_INIT, rb);
          rx_phase = 1;
        end else if (rx_phase == 1) begin
          lsb_hold = rb;
          crc_acc = crc31_byte(crc_acc, rb);
          rx_phase = 2;
        end else begin
          ok = (crc_acc == rb);
          frame_clean = frame_clean & ok;
          fend = (words_done + 1 >= effective_frame_len());
          results_due.push_back('{KIND_RX, 8'h00, {msb_hold, lsb_hold}, ok, frame_clean,
                                  fend, 1'b1});
          if (fend) begin
            words_done = 0;
            frame_clean = 1'b1;
          end else begin
            words_done = words_done + 1;
          end
          rx_phase = 0;
          crc_acc = CRC_INIT;
        end
      end
      FUNC_TX: begin
        tx_crc = crc31_byte(crc31_byte(CRC_INIT, tw[15:8]), tw[7:0]);
        results_due.push_back('{KIND_TX, tw[15:8], 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0});
        results_due.push_back('{KIND_TX, tw[7:0], 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0});
        results_due.push_back('{KIND_TX, tx_crc, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b1});
      end
      default: begin
      end
    endcase
  endtask

  task automatic offer_word(input logic [1:0] f, input logic [7:0] rb, input logic [15:0] tw,
                            input logic typed, input codec_out_t want);
    if (send_pct != 0 && $urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < send_pct);
    end
    in_valid <= 1'b1;
    func <= f;
    rx_byte <= rb;
    tx_word <= tw;
    do @(posedge clk); while (in_ready !== 1'b1);
    codec_predict(f, rb, tw);
    if (typed) begin
      results_due[$] = want;
    end
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (results_due.size() != 0);
  endtask

  task automatic set_frame_len(input logic [4:0] n);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= n;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    frame_len_cfg = n;
  endtask

  task automatic run_random(input int goal, input logic pressure);
    int sent;
    int pick;
    logic held;
    logic paused;
    logic [15:0] w;
    logic [7:0] c;
    sent = 0;
    held = 1'b0;
    paused = 1'b0;
    while (sent < goal) begin
      if (pressure && !held && sent >= 6) begin
        hold_reqs = hold_reqs + 1;
        held = 1'b1;
      end
      if (pressure && !paused && sent >= 20) begin
        drain_results();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      w = 16'($urandom_range(0, 65535));
      if ($urandom_range(0, 9) == 0) begin
        w = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      end
      if (pick < 45) begin
        c = crc31_byte(crc31_byte(CRC_INIT, w[15:8]), w[7:0]);
        if ($urandom_range(0, 7) == 0) begin
          c = c ^ (8'h01 << $urandom_range(0, 7));
        end
        offer_word(FUNC_RX, w[15:8], 16'($urandom), 1'b0, NONE);
        offer_word(FUNC_RX, w[7:0], 16'($urandom), 1'b0, NONE);
        offer_word(FUNC_RX, c, 16'($urandom), 1'b0, NONE);
        sent = sent + 3;
      end else if (pick < 75) begin
        offer_word(FUNC_TX, 8'($urandom), w, 1'b0, NONE);
        sent = sent + 1;
      end else if (pick < 85) begin
        offer_word(FUNC_RX, w[7:0], 16'($urandom), 1'b0, NONE);
        sent = sent + 1;
      end else if (pick < 92) begin
        offer_word(FUNC_RESYNC, 8'($urandom), w, 1'b0, NONE);
        sent = sent + 1;
      end else begin
        offer_word(FUNC_SPARE, 8'($urandom), w, 1'b0, NONE);
        sent = sent + 1;
      end
    end
  endtask

  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want !== got) begin
      $display("%0t %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      error_count = error_count + 1;
    end
  endtask

  always @(posedge clk) begin
    codec_out_t head;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (results_due.size() == 0) begin
        $display("%0t unexpected result word: kind %0h tx_byte %0h rx_word %0h", $time,
                 result_kind, tx_byte, rx_word);
        error_count = error_count + 1;
      end else begin
        head = results_due.pop_front();
        check_field("result_kind", int'(head.kind), int'(result_kind));
        check_field("tx_byte", int'(head.txb), int'(tx_byte));
        check_field("rx_word", int'(head.word), int'(rx_word));
        check_field("word_ok", int'(head.wok), int'(word_ok));
        check_field("frame_ok", int'(head.fok), int'(frame_ok));
        check_field("frame_end", int'(head.fend), int'(frame_end));
        check_field("run_end", int'(head.rend), int'(run_end));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    int phase_len [NUM_PHASES];
    int phase_send [NUM_PHASES];
    int phase_stall [NUM_PHASES];
    phase_len = '{1, 16, 0, 31, 3, 17, 0, 2};
    phase_send = '{0, 75, 0, 29, 0, 29, 75, 0};
    phase_stall = '{0, 0, 75, 29, 0, 29, 0, 75};
    phase_len[6] = $urandom_range(0, 31);

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_ROWS[i]) begin
      offer_word(DIRECTED_ROWS[i].f, DIRECTED_ROWS[i].rb, DIRECTED_ROWS[i].tw,
                 DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
    end

    // Each phase starts idle; the frame position carries over, so a shorter
    // length can land in the middle of a frame.
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clk);
      set_frame_len(5'(phase_len[p]));
      send_pct = phase_send[p];
      stall_pct = phase_stall[p];
      run_random(PHASE_WORDS, p == 4);
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/crc8wfc_pkg.sv
rtl/crc8wfc_fifo.sv
rtl/crc8wfc_front.sv
rtl/crc8wfc_back.sv
rtl/crc8_word_frame_codec.sv
bench/tb_top.sv
